// ===== hdl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator
// Field structs, operation and status codes, controller state encoding.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int HeapBytes  = 65536;
  localparam int Gran       = 16;
  localparam int MaxFree    = 64;
  localparam int StoreDepth = HeapBytes / Gran;
  localparam int FreeAw     = $clog2(MaxFree);
  localparam int StoreAw    = $clog2(StoreDepth);
  localparam int CntW       = $clog2(MaxFree + 1);

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_REINIT = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADADR = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] request_bytes;
    logic [15:0] free_address;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] payload_address;
    logic [16:0] block_bytes;
  } out_beat_t;

  // free list entry: start and length
  typedef struct packed {
    logic [16:0] start;
    logic [16:0] len;
  } fent_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_RD,   // alloc scan: issue read
    S_A_CHK,  // alloc scan: check data
    S_A_UPD,  // alloc: decide split/remove
    S_F_LEN,  // free: wait block length
    S_F_CHK0, // free: validate length
    S_F_RD,   // free scan: issue read
    S_F_CHK,  // free scan: check data
    S_F_DEC,  // free: merge decision
    S_F_NXT,  // free: read entry i+1 for the removal shift
    S_F_WR,   // free: clear block length after merge
    S_SH_RD,  // shift: read
    S_SH_WR,  // shift: write
    S_DONE
  } state_t;

endpackage

// ===== hdl/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// ffba_ram: generic single-port RAM
// One access per cycle: a write also reads the old word; read data registered.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write, and registered read (old data on a write)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/first_fit_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit: first-fit free-list allocator
// Alloc reads and checks free-list entries in order, then splits the first
// fit or takes it whole and shifts later entries down; free looks up the
// block length, scans for overlap and insert point, then merges with one or
// both neighbours or shifts entries up. The done state precedes the one-cycle out_valid strobe.
// One request at a time: busy is high from accept through the strobe cycle and
// while init_r is high after reset (synchronous, rst_n low), which sets one free block.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ffba_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  output ffba_pkg::out_beat_t out_beat,
  input  logic                cfg_we,
  input  logic [16:0]         cfg_wdata
);

  localparam int Aw = ffba_pkg::FreeAw;
  localparam int Sw = ffba_pkg::StoreAw;
  localparam int Cw = ffba_pkg::CntW;

  ffba_pkg::state_t state_r, state_nxt;
  logic [16:0]  region_r;
  logic [16:0]  reff_r, reff_nxt;
  logic [Cw-1:0] cnt_r, cnt_nxt;
  logic [Cw-1:0] i_r, i_nxt;
  logic [Cw-1:0] k_r, k_nxt;
  logic          shl_r, shl_nxt; // 1: shift down (remove), 0: shift up (insert)
  logic [16:0]   need_r, need_nxt;
  logic [16:0]   blk_r, blk_nxt;
  logic [16:0]   len_r, len_nxt;
  logic          mp_r, mp_nxt;
  ffba_pkg::fent_t prev_r, prev_nxt;
  ffba_pkg::fent_t hold_r, hold_nxt;
  ffba_pkg::out_beat_t res_r, res_nxt;
  logic          ov_r, ov_nxt;

  // free list RAM
  logic            fl_we;
  logic [Aw-1:0]   fl_addr;
  ffba_pkg::fent_t fl_wd, fl_rd;
  // free list RAM port after the initial entry write
  logic            flw_we;
  logic [Aw-1:0]   flw_addr;
  ffba_pkg::fent_t flw_wd;
  // block length store RAM
  logic            bs_we;
  logic [Sw-1:0]   bs_addr;
  logic [16:0]     bs_wd, bs_rd;

  ffba_ram #(.Width($bits(ffba_pkg::fent_t)), .Depth(ffba_pkg::MaxFree)) u_flist (
    .clk(clk), .we(flw_we), .addr(flw_addr), .wdata(flw_wd), .rdata(fl_rd)
  );
  ffba_ram #(.Width(17), .Depth(ffba_pkg::StoreDepth)) u_bstore (
    .clk(clk), .we(bs_we), .addr(bs_addr), .wdata(bs_wd), .rdata(bs_rd)
  );

  // effective region: clamp and round down to a granule
  logic [16:0] reg_clamp;
  always_comb begin
    if (region_r < 17'd64) begin
      reg_clamp = 17'd64;
    end else if (region_r > 17'd65536) begin
      reg_clamp = 17'd65536;
    end else begin
      reg_clamp = {region_r[16:4], 4'd0};
    end
  end

  logic [16:0] fl_end;
  assign fl_end = fl_rd.start + fl_rd.len;

  // request decode
  logic [16:0] in_need;
  logic [16:0] in_req_rnd;
  assign in_req_rnd = {1'b0, in_beat.request_bytes} + 17'd15;
  assign in_need    = {in_req_rnd[16:4], 4'd0} + 17'd16;

  // next state and datapath
  always_comb begin
    state_nxt = state_r;
    reff_nxt  = reff_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    shl_nxt   = shl_r;
    need_nxt  = need_r;
    blk_nxt   = blk_r;
    len_nxt   = len_r;
    mp_nxt    = mp_r;
    prev_nxt  = prev_r;
    hold_nxt  = hold_r;
    res_nxt   = res_r;
    ov_nxt    = 1'b0;
    fl_we     = 1'b0;
    fl_addr   = i_r[Aw-1:0];
    fl_wd     = fl_rd;
    bs_we     = 1'b0;
    bs_addr   = blk_r[Sw+3:4];
    bs_wd     = 17'd0;

    case (state_r)
      ffba_pkg::S_IDLE: begin
        if (start && !busy) begin
          need_nxt = in_need;
          blk_nxt  = {1'b0, in_beat.free_address} - 17'd16;
          i_nxt    = '0;
          res_nxt  = '0;
          case (in_beat.kind)
            ffba_pkg::KIND_ALLOC: begin
              state_nxt = ffba_pkg::S_A_RD;
            end
            ffba_pkg::KIND_FREE: begin
              if (in_beat.free_address < 16'd32 || in_beat.free_address[3:0] != 4'd0 ||
                  ({1'b0, in_beat.free_address} - 17'd16) >= reff_r) begin
                res_nxt.status = ffba_pkg::ST_BADADR;
                state_nxt      = ffba_pkg::S_DONE;
              end else begin
                bs_addr   = in_beat.free_address[Sw+3:4] - Sw'(1);
                state_nxt = ffba_pkg::S_F_LEN;
              end
            end
            ffba_pkg::KIND_REINIT: begin
              reff_nxt  = reg_clamp;
              cnt_nxt   = Cw'(1);
              fl_we     = 1'b1;
              fl_addr   = '0;
              fl_wd     = '{start: 17'd16, len: reg_clamp - 17'd16};
              state_nxt = ffba_pkg::S_DONE;
            end
            default: begin
              state_nxt = ffba_pkg::S_DONE;
            end
          endcase
        end
      end

      // alloc scan
      ffba_pkg::S_A_RD: begin
        if (i_r >= cnt_r) begin
          res_nxt.status = ffba_pkg::ST_NOFIT;
          state_nxt      = ffba_pkg::S_DONE;
        end else begin
          state_nxt = ffba_pkg::S_A_CHK;
        end
      end
      ffba_pkg::S_A_CHK: begin
        if (fl_rd.len >= need_r) begin
          blk_nxt  = fl_rd.start;
          hold_nxt = fl_rd;
          state_nxt = ffba_pkg::S_A_UPD;
        end else begin
          i_nxt     = i_r + Cw'(1);
          fl_addr   = Aw'(i_r + Cw'(1));
          state_nxt = ffba_pkg::S_A_RD;
        end
      end
      ffba_pkg::S_A_UPD: begin
        res_nxt.payload_address = 16'(blk_r + 17'd16);
        bs_we   = 1'b1;
        if (hold_r.len - need_r >= 17'd16) begin
          fl_we   = 1'b1;
          fl_wd   = '{start: hold_r.start + need_r, len: hold_r.len - need_r};
          bs_wd   = need_r;
          res_nxt.block_bytes = need_r;
          state_nxt = ffba_pkg::S_DONE;
        end else begin
          bs_wd   = hold_r.len;
          res_nxt.block_bytes = hold_r.len;
          cnt_nxt = cnt_r - Cw'(1);
          shl_nxt = 1'b1;
          k_nxt   = i_r + Cw'(1);
          fl_addr = Aw'(i_r + Cw'(1));
          state_nxt = ffba_pkg::S_SH_RD;
        end
      end

      // free: length lookup
      ffba_pkg::S_F_LEN: begin
        state_nxt = ffba_pkg::S_F_CHK0;
      end
      ffba_pkg::S_F_CHK0: begin
        len_nxt = bs_rd;
        if (bs_rd == 17'd0 || bs_rd > reff_r - blk_r) begin
          res_nxt.status = ffba_pkg::ST_BADADR;
          state_nxt      = ffba_pkg::S_DONE;
        end else begin
          fl_addr   = '0;
          i_nxt     = '0;
          mp_nxt    = 1'b0;
          state_nxt = ffba_pkg::S_F_RD;
        end
      end
      // free scan: overlap check and insert point (list is sorted)
      ffba_pkg::S_F_RD: begin
        if (i_r >= cnt_r) begin
          state_nxt = ffba_pkg::S_F_DEC;
        end else begin
          state_nxt = ffba_pkg::S_F_CHK;
        end
      end
      ffba_pkg::S_F_CHK: begin
        if (blk_r < fl_end && fl_rd.start < blk_r + len_r) begin
          res_nxt.status = ffba_pkg::ST_BADADR;
          state_nxt      = ffba_pkg::S_DONE;
        end else if (fl_rd.start > blk_r) begin
          hold_nxt  = fl_rd;
          state_nxt = ffba_pkg::S_F_DEC;
        end else begin
          prev_nxt  = fl_rd;
          mp_nxt    = (fl_end == blk_r);
          i_nxt     = i_r + Cw'(1);
          fl_addr   = Aw'(i_r + Cw'(1));
          state_nxt = ffba_pkg::S_F_RD;
        end
      end
      ffba_pkg::S_F_DEC: begin
        // hold_r valid only when i < cnt
        if (mp_r && i_r < cnt_r && blk_r + len_r == hold_r.start) begin
          fl_we   = 1'b1;
          fl_addr = Aw'(i_r - Cw'(1));
          fl_wd   = '{start: prev_r.start, len: prev_r.len + len_r + hold_r.len};
          cnt_nxt = cnt_r - Cw'(1);
          shl_nxt = 1'b1;
          k_nxt   = i_r + Cw'(1);
          state_nxt = ffba_pkg::S_F_NXT;
        end else if (mp_r) begin
          fl_we   = 1'b1;
          fl_addr = Aw'(i_r - Cw'(1));
          fl_wd   = '{start: prev_r.start, len: prev_r.len + len_r};
          state_nxt = ffba_pkg::S_F_WR;
        end else if (i_r < cnt_r && blk_r + len_r == hold_r.start) begin
          fl_we   = 1'b1;
          fl_wd   = '{start: blk_r, len: hold_r.len + len_r};
          state_nxt = ffba_pkg::S_F_WR;
        end else if (cnt_r >= Cw'(ffba_pkg::MaxFree)) begin
          res_nxt.status = ffba_pkg::ST_FULL;
          state_nxt      = ffba_pkg::S_DONE;
        end else begin
          // insert: shift entries [i, cnt) up by one, from the top
          shl_nxt   = 1'b0;
          k_nxt     = cnt_r;
          cnt_nxt   = cnt_r + Cw'(1);
          fl_addr   = Aw'(cnt_r - Cw'(1));
          state_nxt = ffba_pkg::S_SH_RD;
        end
      end
      // merge of both sides: removal shift of entry i, with read issued
      ffba_pkg::S_F_NXT: begin
        fl_addr   = Aw'(k_r);
        bs_we     = 1'b1;
        res_nxt.block_bytes = len_r;
        state_nxt = ffba_pkg::S_SH_RD;
      end
      ffba_pkg::S_F_WR: begin
        bs_we     = 1'b1;
        res_nxt.block_bytes = len_r;
        state_nxt = ffba_pkg::S_DONE;
      end

      // list shift: shl moves k -> k-1 for k < cnt+1; otherwise k-1 -> k
      ffba_pkg::S_SH_RD: begin
        if (shl_r) begin
          if (k_r > cnt_r) begin
            state_nxt = ffba_pkg::S_DONE;
          end else begin
            fl_addr   = Aw'(k_r);
            state_nxt = ffba_pkg::S_SH_WR;
          end
        end else begin
          if (k_r <= i_r) begin
            fl_we   = 1'b1;
            fl_addr = Aw'(i_r);
            fl_wd   = '{start: blk_r, len: len_r};
            bs_we   = 1'b1;
            res_nxt.block_bytes = len_r;
            state_nxt = ffba_pkg::S_DONE;
          end else begin
            fl_addr   = Aw'(k_r - Cw'(1));
            state_nxt = ffba_pkg::S_SH_WR;
          end
        end
      end
      ffba_pkg::S_SH_WR: begin
        fl_we = 1'b1;
        if (shl_r) begin
          fl_addr = Aw'(k_r - Cw'(1));
          k_nxt   = k_r + Cw'(1);
        end else begin
          fl_addr = Aw'(k_r);
          k_nxt   = k_r - Cw'(1);
        end
        state_nxt = ffba_pkg::S_SH_RD;
      end

      ffba_pkg::S_DONE: begin
        ov_nxt    = 1'b1;
        state_nxt = ffba_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ffba_pkg::S_IDLE;
      end
    endcase
  end

  // after reset, entry 0 must be written once before the first request
  logic init_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ffba_pkg::S_IDLE;
      region_r <= 17'd65536;
      reff_r   <= 17'd65536;
      cnt_r    <= Cw'(1);
      ov_r     <= 1'b0;
      init_r   <= 1'b1;
    end else begin
      state_r <= init_r ? ffba_pkg::S_IDLE : state_nxt;
      reff_r  <= reff_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      init_r  <= 1'b0;
      if (cfg_we) begin
        region_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    k_r    <= k_nxt;
    shl_r  <= shl_nxt;
    need_r <= need_nxt;
    blk_r  <= blk_nxt;
    len_r  <= len_nxt;
    mp_r   <= mp_nxt;
    prev_r <= prev_nxt;
    hold_r <= hold_nxt;
    res_r  <= res_nxt;
  end

  // write of initial entry: reuse the RAM port while init_r is high
  always_comb begin
    flw_we   = fl_we;
    flw_addr = fl_addr;
    flw_wd   = fl_wd;
    if (init_r) begin
      flw_we   = 1'b1;
      flw_addr = '0;
      flw_wd   = '{start: 17'd16, len: 17'd65520};
    end
  end

  assign busy      = (state_r != ffba_pkg::S_IDLE) || init_r || ov_r;
  assign out_valid = ov_r;
  assign out_beat  = res_r;

endmodule
